@@ hw/rtl/bla_pkg.sv @@
// shared constants, types and codes for the bakery lock arbiter
// no dependencies; imported by bla_cell and bakery_lock_arbiter_top
package bla_pkg;

  localparam int THREADS    = 8;
  localparam int LABEL_BITS = 16;
  localparam int TICKET_W   = 16;
  localparam int ID_W       = 3;
  localparam int ACT_W      = 4;

  typedef logic [LABEL_BITS-1:0] label_t;

  localparam label_t LABEL_MAX = {LABEL_BITS{1'b1}};

  typedef enum logic [1:0] {
    OP_TAKE    = 2'd0,
    OP_POLL    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_FIN  = 2'd2
  } state_t;

  // scan token walking along the row of cells
  typedef struct packed {
    logic   valid;
    label_t max_label;
    logic   any_other;
    logic   blk_sat;
    logic   blk;
  } tok_t;

  // static per-cell view of the current request
  typedef struct packed {
    logic examined;
    logic is_self;
    logic below_self;
  } cell_ctl_t;

  typedef struct packed {
    logic   en;
    logic   flag;
    label_t label;
  } cell_wr_t;

endpackage

@@ hw/rtl/bla_cell.sv @@
// one requester entry: flag and label, plus one stage of the scan token
// depends on bla_pkg
module bla_cell
  import bla_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  cell_wr_t  wr,
  input  label_t    who_label,
  input  tok_t      tok_in,
  output tok_t      tok_out,
  output logic      flag_o,
  output label_t    label_o
);

  logic   flag_r;
  logic   flag_nxt;
  label_t label_r;
  label_t label_nxt;
  tok_t   tok_r;
  tok_t   tok_nxt;
  logic   other;

  assign other = ctl.examined && !ctl.is_self && flag_r;

  always_comb begin
    tok_nxt           = tok_in;
    tok_nxt.max_label = (label_r > tok_in.max_label) ? label_r : tok_in.max_label;
    tok_nxt.any_other = tok_in.any_other | other;
    // after a saturated take the requester sits at the maximum label
    tok_nxt.blk_sat   = tok_in.blk_sat | (other && ((label_r != LABEL_MAX) || ctl.below_self));
    tok_nxt.blk       = tok_in.blk | (other && ((label_r < who_label) ||
                        ((label_r == who_label) && ctl.below_self)));
  end

  always_comb begin
    flag_nxt  = wr.en ? wr.flag : flag_r;
    label_nxt = wr.en ? wr.label : label_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r      <= 1'b0;
      label_r     <= '0;
      tok_r.valid <= 1'b0;
    end else begin
      flag_r      <= flag_nxt;
      label_r     <= label_nxt;
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.max_label <= tok_nxt.max_label;
    tok_r.any_other <= tok_nxt.any_other;
    tok_r.blk_sat   <= tok_nxt.blk_sat;
    tok_r.blk       <= tok_nxt.blk;
  end

  assign tok_out = tok_r;
  assign flag_o  = flag_r;
  assign label_o = label_r;

endmodule

@@ hw/rtl/bakery_lock_arbiter_top.sv @@
// Bakery lock arbiter: one result for every request. A request is taken only while idle: the
// accept cycle registers it and launches a scan token, which walks the row through the token
// register of each requester cell, collecting the largest label and any blocking entry; when
// it leaves the last cell the requester's entry is updated and the result register loaded,
// then the result moves into the output register and the block returns to idle for the next
// request. A stalled result holds the block in its final stage. A new request is taken once
// the previous result has been loaded, whether or not it has been taken yet.
// depends on bla_pkg and bla_cell
module bakery_lock_arbiter_top
  import bla_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_operation,
  input  logic [ID_W-1:0]     in_thread_id,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_may_enter,
  output logic [TICKET_W-1:0] out_ticket,
  output logic                out_ticket_saturated,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [ACT_W-1:0]    cfg_data
);

  state_t state_r, state_nxt;
  logic [ACT_W-1:0] active_r;
  op_t              op_r;
  logic [ID_W-1:0]  who_r;
  logic             who_ok_r;
  logic             who_flag_r;
  label_t           who_label_r;
  logic             start_r;

  logic             res_may_r;
  label_t           res_ticket_r;
  logic             res_sat_r;

  logic             out_valid_r;
  logic             out_may_r;
  logic [TICKET_W-1:0] out_ticket_r;
  logic             out_sat_r;

  tok_t             tok_chain [THREADS+1];
  logic [THREADS-1:0] tok_vld;
  cell_ctl_t        ctl [THREADS];
  cell_wr_t         wr [THREADS];
  logic             cell_flag [THREADS];
  label_t           cell_label [THREADS];

  logic   accept;
  logic   res_load;
  logic   out_load;
  logic   sel_flag;
  label_t sel_label;
  logic   sat_c;
  label_t new_label_c;
  logic   may_c;
  label_t ticket_c;
  logic   upd_en;
  logic   upd_flag;
  label_t upd_label;
  tok_t   last;

  assign last = tok_chain[THREADS];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_SCAN;
      S_SCAN:  if (last.valid) state_nxt = S_FIN;
      S_FIN:   if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall = 1'b1;
    res_load = 1'b0;
    out_load = 1'b0;
    case (state_r)
      S_IDLE:  in_stall = 1'b0;
      S_SCAN:  res_load = last.valid;
      S_FIN:   out_load = !out_valid_r || !out_stall;
      default: in_stall = 1'b1;
    endcase
  end

  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // pick the requester's entry at accept time
  always_comb begin
    sel_flag  = 1'b0;
    sel_label = '0;
    for (int i = 0; i < THREADS; i++) begin
      if (32'(i) == 32'(in_thread_id)) begin
        sel_flag  = cell_flag[i];
        sel_label = cell_label[i];
      end
    end
  end

  assign tok_chain[0] = '{valid: start_r, max_label: '0, any_other: 1'b0,
                          blk_sat: 1'b0, blk: 1'b0};

  genvar g;
  generate
    for (g = 0; g < THREADS; g++) begin : g_cell
      assign ctl[g].examined   = 32'(g) < 32'(active_r);
      assign ctl[g].is_self    = 32'(g) == 32'(who_r);
      assign ctl[g].below_self = 32'(g) < 32'(who_r);
      assign wr[g].en          = upd_en && ctl[g].is_self;
      assign wr[g].flag        = upd_flag;
      assign wr[g].label       = upd_label;
      assign tok_vld[g]        = tok_chain[g+1].valid;

      bla_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl[g]),
        .wr        (wr[g]),
        .who_label (who_label_r),
        .tok_in    (tok_chain[g]),
        .tok_out   (tok_chain[g+1]),
        .flag_o    (cell_flag[g]),
        .label_o   (cell_label[g])
      );
    end
  endgenerate

  // result and entry update once the token leaves the last cell
  always_comb begin
    sat_c       = (last.max_label == LABEL_MAX);
    new_label_c = sat_c ? LABEL_MAX : label_t'(last.max_label + label_t'(1));
    upd_en      = 1'b0;
    upd_flag    = who_flag_r;
    upd_label   = who_label_r;
    may_c       = who_flag_r && !last.blk;
    ticket_c    = who_label_r;
    case (op_r)
      OP_TAKE: begin
        upd_en    = res_load && who_ok_r;
        upd_flag  = 1'b1;
        upd_label = new_label_c;
        ticket_c  = new_label_c;
        // the new label is above every other, unless it saturated
        may_c     = sat_c ? !last.blk_sat : !last.any_other;
      end
      OP_RELEASE: begin
        upd_en   = res_load && who_ok_r;
        upd_flag = 1'b0;
        may_c    = 1'b0;
      end
      default: begin
        upd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= ACT_W'(8);
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= accept;
      if (cfg_valid && cfg_ready) begin
        active_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      op_r        <= op_t'(in_operation);
      who_r       <= in_thread_id;
      who_ok_r    <= 32'(in_thread_id) < THREADS;
      who_flag_r  <= sel_flag;
      who_label_r <= sel_label;
    end
    if (res_load) begin
      res_may_r    <= who_ok_r && may_c;
      res_ticket_r <= who_ok_r ? ticket_c : '0;
      res_sat_r    <= who_ok_r && (op_r == OP_TAKE) && sat_c;
    end
    if (out_load) begin
      out_may_r    <= res_may_r;
      out_ticket_r <= TICKET_W'(res_ticket_r);
      out_sat_r    <= res_sat_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_may_enter        = out_may_r;
  assign out_ticket           = out_ticket_r;
  assign out_ticket_saturated = out_sat_r;

`ifndef SYNTHESIS
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({tok_vld, start_r}))
    else $error("more than one scan token in flight");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> (tok_vld == '0) && !start_r)
    else $error("request taken while a scan is still running");

  a_write_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    upd_en |-> (state_r == S_SCAN) && last.valid)
    else $error("entry written outside the end of a scan");

  a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) && last.valid |=> (state_r == S_FIN))
    else $error("scan finished without moving to result stage");
`endif

endmodule

@@ dv/tb_bakery_lock_arbiter_top.sv @@
// self-checking testbench for the bakery lock arbiter: directed and random requests
// holds its own prediction of flags, labels and the active count; depends on bla_pkg and the rtl
`timescale 1ns / 100ps

module tb_bakery_lock_arbiter_top;
  import bla_pkg::*;

  typedef struct packed {
    logic   may_enter;
    label_t ticket;
    logic   saturated;
  } grant_t;

  class grant_board;
    logic             held [THREADS];
    label_t           label [THREADS];
    logic [ACT_W-1:0] active;
    grant_t           due [$];
    int               errors;

    function new();
      for (int i = 0; i < THREADS; i++) begin
        held[i]  = 1'b0;
        label[i] = '0;
      end
      active = ACT_W'(THREADS);
      errors = 0;
    endfunction

    function void set_active(logic [ACT_W-1:0] v);
      active = v;
    endfunction

    function logic holds(int who);
      return held[who];
    endfunction

    function int pending_count();
      return due.size();
    endfunction

    // stale labels of released requesters count as well
    function label_t top_label();
      label_t top;
      top = '0;
      for (int i = 0; i < THREADS; i++)
        if (label[i] > top) top = label[i];
      return top;
    endfunction

    function logic may_enter_now(int who);
      int lim;
      lim = (active > THREADS) ? THREADS : int'(active);
      if (!held[who]) return 1'b0;
      for (int i = 0; i < lim; i++) begin
        if (i == who || !held[i]) continue;
        if (label[i] < label[who]) return 1'b0;
        if (label[i] == label[who] && i < who) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_request(op_t op, int who);
      grant_t g;
      label_t top;
      g.saturated = 1'b0;
      if (op == OP_TAKE) begin
        top = top_label();
        held[who] = 1'b1;
        if (top == LABEL_MAX) begin
          label[who]  = LABEL_MAX;
          g.saturated = 1'b1;
        end else begin
          label[who] = top + 1'b1;
        end
      end else if (op == OP_RELEASE) begin
        held[who] = 1'b0;
      end
      g.may_enter = may_enter_now(who);
      g.ticket    = label[who];
      due.push_back(g);
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_grant(logic may_enter, label_t ticket, logic saturated);
      grant_t want;
      if (due.size() == 0) begin
        report_mismatch("result with no request outstanding");
        return;
      end
      want = due.pop_front();
      if (may_enter !== want.may_enter)
        report_mismatch($sformatf("may_enter %b, predicted %b", may_enter, want.may_enter));
      if (ticket !== want.ticket)
        report_mismatch($sformatf("ticket %0d, predicted %0d", ticket, want.ticket));
      if (saturated !== want.saturated)
        report_mismatch($sformatf("ticket_saturated %b, predicted %b",
                                  saturated, want.saturated));
    endtask

    task flush_leftover();
      while (due.size() != 0) begin
        void'(due.pop_front());
        report_mismatch("predicted result never came out");
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          in_operation = OP_POLL;
  logic [ID_W-1:0]     in_thread_id = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_may_enter;
  logic [TICKET_W-1:0] out_ticket;
  logic                out_ticket_saturated;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [ACT_W-1:0]    cfg_data = '0;

  grant_board sb;
  logic       gaps_on = 1'b1;

  bakery_lock_arbiter_top u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_operation         (in_operation),
    .in_thread_id         (in_thread_id),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_may_enter        (out_may_enter),
    .out_ticket           (out_ticket),
    .out_ticket_saturated (out_ticket_saturated),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_data             (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < 14);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_request(op_t'(in_operation), int'(in_thread_id));
    if (rst_n && cfg_valid && cfg_ready)
      sb.set_active(cfg_data);
    if (rst_n && out_valid && !out_stall)
      sb.check_grant(out_may_enter, out_ticket, out_ticket_saturated);
  end

  // valid stays high on return so the next request can follow back to back
  task automatic push_request(op_t op, int who);
    in_valid     <= 1'b1;
    in_operation <= op;
    in_thread_id <= ID_W'(who);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic maybe_idle();
    while (gaps_on && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // lock usage pattern: take, spin on polls, release; with a little noise
  task automatic random_request();
    int   who;
    int   r;
    op_t  op;
    who = $urandom_range(THREADS - 1);
    r   = $urandom_range(99);
    if (r < 5)
      op = OP_NONE;
    else if (!sb.holds(who))
      op = (r < 80) ? OP_TAKE : ((r < 90) ? OP_POLL : OP_RELEASE);
    else
      op = (r < 60) ? OP_POLL : ((r < 88) ? OP_RELEASE : OP_TAKE);
    push_request(op, who);
  endtask

  // only once every outstanding request has produced its result
  task automatic write_active(logic [ACT_W-1:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_count() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty lock, releasing an unheld entry, unused code
    push_request(OP_POLL, 0);
    push_request(OP_RELEASE, 7);
    push_request(OP_NONE, 3);
    push_request(OP_TAKE, 0);
    push_request(OP_TAKE, 7);
    push_request(OP_POLL, 7);
    push_request(OP_POLL, 0);
    push_request(OP_TAKE, 3);
    push_request(OP_RELEASE, 0);
    push_request(OP_POLL, 7);
    push_request(OP_NONE, 7);
    // re-take after release gets a label above the stale ones
    push_request(OP_TAKE, 0);
    push_request(OP_POLL, 0);
    push_request(OP_RELEASE, 7);
    push_request(OP_POLL, 3);
    push_request(OP_RELEASE, 3);
    push_request(OP_RELEASE, 0);
    push_request(OP_TAKE, 5);
    push_request(OP_TAKE, 6);
    push_request(OP_POLL, 6);
    push_request(OP_NONE, 5);
    push_request(OP_POLL, 5);

    // step through every active count, 0 and 15 included
    for (int p = 0; p < 16; p++) begin
      write_active(ACT_W'((p * 7 + 8) % 16));
      gaps_on = (p != 5);
      repeat (60) begin
        maybe_idle();
        random_request();
      end
    end

    // every requester queued, then polled in id order
    write_active(ACT_W'(THREADS));
    gaps_on = 1'b0;
    for (int i = 0; i < THREADS; i++) push_request(OP_TAKE, i);
    for (int i = 0; i < THREADS; i++) push_request(OP_POLL, i);
    push_request(OP_RELEASE, 0);
    push_request(OP_POLL, 1);
    push_request(OP_POLL, 2);
    write_active(ACT_W'(3));
    push_request(OP_POLL, 5);
    write_active('0);
    push_request(OP_POLL, 7);
    push_request(OP_TAKE, 0);
    push_request(OP_POLL, 0);

    gaps_on = 1'b1;
    write_active(ACT_W'(5));
    repeat (60) begin
      maybe_idle();
      random_request();
    end

    in_valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    sb.flush_leftover();
    if (sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #12_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/bla_pkg.sv
hw/rtl/bla_cell.sv
hw/rtl/bakery_lock_arbiter_top.sv
dv/tb_bakery_lock_arbiter_top.sv
